// File: rtl/abtd_pkg.sv
package abtd_pkg;

  localparam int MAX_BLOCK = 64;
  localparam int ADDR_W    = $clog2(MAX_BLOCK);
  localparam int LEN_W     = ADDR_W + 1;
  localparam int CFG_IDX_W = 2;

  localparam logic [7:0] PAD_CHAR = 8'h2A;

  localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_LEN  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MULTIPLIER = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_OFFSET     = 2'd2;

  localparam logic [LEN_W-1:0]  RST_BLOCK_LEN  = LEN_W'(8);
  localparam logic [ADDR_W-1:0] RST_MULTIPLIER = ADDR_W'(1);
  localparam logic [ADDR_W-1:0] RST_OFFSET     = ADDR_W'(0);

  // one flushed block waiting for read-out
  typedef struct packed {
    logic [LEN_W-1:0] fill;
    logic             done;
  } desc_t;

  // block store write port, bank bit on top of the position
  typedef struct packed {
    logic              en;
    logic [ADDR_W:0]   addr;
    logic [7:0]        data;
  } mem_wr_t;

  // derived decode parameters
  typedef struct packed {
    logic              ready;
    logic [LEN_W-1:0]  n_len;
    logic [ADDR_W-1:0] inv_mult;
    logic [LEN_W-1:0]  inv_off;
  } drv_t;

endpackage

// File: rtl/abtd_derive.sv
module abtd_derive import abtd_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [LEN_W-1:0]     cfg_data,
  output drv_t                 drv
);

  typedef enum logic [2:0] {D_LOAD, D_REDM, D_SRCH, D_REDO, D_MULO, D_DONE} dstate_t;

  dstate_t           state;
  logic [LEN_W-1:0]  n_len;
  logic [ADDR_W-1:0] mult;
  logic [ADDR_W-1:0] offs;
  logic [ADDR_W-1:0] m;
  logic [ADDR_W-1:0] o;
  logic [ADDR_W-1:0] acc;
  logic [ADDR_W-1:0] inv;
  logic [ADDR_W-1:0] k;
  logic [LEN_W-1:0]  i;
  logic [LEN_W-1:0]  ioff;
  logic [ADDR_W-1:0] add_b;
  logic [LEN_W-1:0]  sum;
  logic [LEN_W-1:0]  sum_red;
  logic [LEN_W-1:0]  len_clip;
  logic              cfg_hit;

  // shared modular accumulator: acc stays below n, the addend too
  assign add_b   = (state == D_SRCH) ? m : inv;
  assign sum     = {1'b0, acc} + {1'b0, add_b};
  assign sum_red = (sum >= n_len) ? sum - n_len : sum;

  assign len_clip = (cfg_data == '0) ? LEN_W'(1) :
                    (cfg_data > LEN_W'(MAX_BLOCK)) ? LEN_W'(MAX_BLOCK) : cfg_data;

  assign cfg_hit = cfg_we && (cfg_index inside {CFG_BLOCK_LEN, CFG_MULTIPLIER, CFG_OFFSET});

  assign drv = '{ready: (state == D_DONE), n_len: n_len, inv_mult: inv, inv_off: ioff};

  always_ff @(posedge clk) begin
    if (rst) begin
      n_len <= RST_BLOCK_LEN;
      mult  <= RST_MULTIPLIER;
      offs  <= RST_OFFSET;
      state <= D_LOAD;
    end else if (cfg_hit) begin
      unique case (cfg_index)
        CFG_BLOCK_LEN:  n_len <= len_clip;
        CFG_MULTIPLIER: mult  <= cfg_data[ADDR_W-1:0];
        CFG_OFFSET:     offs  <= cfg_data[ADDR_W-1:0];
        default: ;
      endcase
      state <= D_LOAD;
    end else begin
      unique case (state)
        D_LOAD: begin
          m     <= mult;
          o     <= offs;
          state <= D_REDM;
        end
        D_REDM: begin
          if ({1'b0, m} >= n_len) begin
            m <= m - n_len[ADDR_W-1:0];
          end else begin
            acc   <= m;
            i     <= LEN_W'(1);
            state <= D_SRCH;
          end
        end
        // acc holds m*i mod n
        D_SRCH: begin
          if (i >= n_len) begin
            inv   <= '0;
            state <= D_REDO;
          end else if (acc == ADDR_W'(1)) begin
            inv   <= i[ADDR_W-1:0];
            state <= D_REDO;
          end else begin
            acc <= sum_red[ADDR_W-1:0];
            i   <= i + LEN_W'(1);
          end
        end
        D_REDO: begin
          if ({1'b0, o} >= n_len) begin
            o <= o - n_len[ADDR_W-1:0];
          end else begin
            acc   <= '0;
            k     <= '0;
            state <= D_MULO;
          end
        end
        // acc holds inv*k mod n
        D_MULO: begin
          if (k == o) begin
            ioff  <= n_len - {1'b0, acc};
            state <= D_DONE;
          end else begin
            acc <= sum_red[ADDR_W-1:0];
            k   <= k + ADDR_W'(1);
          end
        end
        D_DONE: ;
        default: state <= D_LOAD;
      endcase
    end
  end

endmodule

// File: rtl/abtd_front.sv
module abtd_front import abtd_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             s_tvalid,
  output logic             s_tready,
  input  logic [7:0]       s_tdata,
  input  logic             s_tlast,
  input  logic [LEN_W-1:0] n_len,
  input  logic             q_full,
  output logic             push,
  output desc_t            push_data,
  output mem_wr_t          wr
);

  logic [LEN_W-1:0] fill;
  logic [LEN_W-1:0] fill_inc;
  logic             wr_bank;
  logic             accept;
  logic             room;
  logic             flush;

  // a full queue means both banks are held by the back end
  assign s_tready = !q_full;
  assign accept   = s_tvalid && s_tready;
  assign room     = fill < LEN_W'(MAX_BLOCK);
  assign fill_inc = room ? fill + LEN_W'(1) : fill;
  assign flush    = s_tlast || (fill_inc >= n_len);

  assign push      = accept && flush;
  assign push_data = '{fill: fill_inc, done: s_tlast};
  assign wr        = '{en: accept && room, addr: {wr_bank, fill[ADDR_W-1:0]}, data: s_tdata};

  always_ff @(posedge clk) begin
    if (rst) begin
      fill    <= '0;
      wr_bank <= 1'b0;
    end else if (accept) begin
      if (flush) begin
        fill    <= '0;
        wr_bank <= ~wr_bank;
      end else begin
        fill <= fill_inc;
      end
    end
  end

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= LEN_W'(MAX_BLOCK))
    else $error("fill count beyond block store");

endmodule

// File: rtl/abtd_queue.sv
module abtd_queue import abtd_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  push,
  input  desc_t push_data,
  input  logic  pop,
  output logic  full,
  output logic  valid,
  output desc_t rd_data
);

  desc_t      ent [2];
  logic       wp;
  logic       rp;
  logic [1:0] cnt;

  assign full    = (cnt == 2'd2);
  assign valid   = (cnt != 2'd0);
  assign rd_data = ent[rp];

  always_ff @(posedge clk) begin
    if (push) begin
      ent[wp] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= 1'b0;
      rp  <= 1'b0;
      cnt <= '0;
    end else begin
      if (push) wp <= ~wp;
      if (pop)  rp <= ~rp;
      cnt <= cnt + 2'(push) - 2'(pop);
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    cnt <= 2'd2)
    else $error("descriptor queue overrun");

endmodule

// File: rtl/abtd_back.sv
module abtd_back import abtd_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  drv_t       drv,
  input  logic       q_valid,
  input  desc_t      q_data,
  output logic       pop,
  input  mem_wr_t    wr,
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata,
  output logic       m_tlast,
  output logic       m_tuser
);

  typedef enum logic [1:0] {B_IDLE, B_RD, B_CHK, B_FIN} bstate_t;

  // two banks: front fills one while this side reads the other
  logic [7:0]        store [2*MAX_BLOCK];
  logic [7:0]        mem_q;

  bstate_t           state;
  logic              rd_bank;
  logic [ADDR_W-1:0] j;
  logic [ADDR_W-1:0] p;
  logic              rd_pad;
  logic              pend_valid;
  logic [7:0]        pend_byte;

  logic              out_free;
  logic              keep;
  logic              last_j;
  logic              emit;
  logic [LEN_W-1:0]  p_sum;
  logic [LEN_W-1:0]  p_next;
  logic [ADDR_W-1:0] p_start;

  assign out_free = !m_tvalid || m_tready;
  assign keep     = !rd_pad && (mem_q != PAD_CHAR);
  assign last_j   = ({1'b0, j} == drv.n_len - LEN_W'(1));
  assign p_sum    = {1'b0, p} + {1'b0, drv.inv_mult};
  assign p_next   = (p_sum >= drv.n_len) ? p_sum - drv.n_len : p_sum;
  assign p_start  = (drv.inv_off == drv.n_len) ? '0 : drv.inv_off[ADDR_W-1:0];
  assign pop      = (state == B_FIN) && (!pend_valid || out_free);
  assign emit     = ((state == B_CHK) && keep && pend_valid && out_free) ||
                    (pop && pend_valid);

  always_ff @(posedge clk) begin
    if (wr.en) begin
      store[wr.addr] <= wr.data;
    end
    mem_q <= store[{rd_bank, p}];
  end

  // one byte is held back so the last kept byte of a block can carry tlast
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= B_IDLE;
      rd_bank    <= 1'b0;
      pend_valid <= 1'b0;
      m_tvalid   <= 1'b0;
    end else begin
      if (emit) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        B_IDLE: begin
          if (q_valid && drv.ready) begin
            p     <= p_start;
            j     <= '0;
            state <= B_RD;
          end
        end
        B_RD: begin
          rd_pad <= ({1'b0, p} >= q_data.fill);
          state  <= B_CHK;
        end
        B_CHK: begin
          if (!(keep && pend_valid && !out_free)) begin
            if (keep) begin
              if (pend_valid) begin
                m_tdata  <= pend_byte;
                m_tlast  <= 1'b0;
                m_tuser  <= q_data.done;
              end
              pend_byte  <= mem_q;
              pend_valid <= 1'b1;
            end
            if (last_j) begin
              state <= B_FIN;
            end else begin
              j     <= j + ADDR_W'(1);
              p     <= p_next[ADDR_W-1:0];
              state <= B_RD;
            end
          end
        end
        B_FIN: begin
          if (pop) begin
            if (pend_valid) begin
              m_tdata  <= pend_byte;
              m_tlast  <= 1'b1;
              m_tuser  <= q_data.done;
            end
            pend_valid <= 1'b0;
            rd_bank    <= ~rd_bank;
            state      <= B_IDLE;
          end
        end
        default: state <= B_IDLE;
      endcase
    end
  end

  a_busy_has_desc: assert property (@(posedge clk) disable iff (rst)
    state != B_IDLE |-> q_valid)
    else $error("read-out running without a queued block");

  a_idle_no_pend: assert property (@(posedge clk) disable iff (rst)
    state == B_IDLE |-> !pend_valid)
    else $error("held byte left over after block end");

  a_mid_push: assert property (@(posedge clk) disable iff (rst)
    (state == B_CHK && keep && pend_valid && out_free) |=> (m_tvalid && !m_tlast))
    else $error("held byte not forwarded");

endmodule

// File: rtl/affine_block_transposition_decoder_top.sv
// Affine block transposition decoder.
// Input stream (s_*): one ciphertext byte per beat, s_tlast marks the last
// byte of a message. Output stream (m_*): decoded bytes, m_tlast on the last
// byte of a block, m_tuser set on every byte of the block ending a message.
// Pad bytes ('*') are never output; a block of only pads gives no beats.
// Config: cfg_we/cfg_index/cfg_data, index 0 block_len, 1 multiplier,
// 2 offset; write only while the block is idle.
// Throughput: bytes are taken one per cycle while a store bank is free; two
// banks let one block fill while the previous one is read out. Read-out takes
// each block position through a store read, then a check.
// After reset and after each config write to index 0, 1 or 2 the inverse
// parameters are found by a serial search; read-out waits for it.
// Reset (rst, synchronous) empties the queue and store fill, restores the
// register defaults and restarts the search. A stalled m_tready holds the
// output register; read-out then stops and the input stalls once both banks
// are full.
module affine_block_transposition_decoder_top import abtd_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [7:0]           s_tdata,   // cipher_byte
  input  logic                 s_tlast,
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [7:0]           m_tdata,   // plain_byte
  output logic                 m_tlast,
  output logic                 m_tuser,   // message_done
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [LEN_W-1:0]     cfg_data
);

  drv_t    drv;
  desc_t   push_data;
  desc_t   q_data;
  mem_wr_t wr;
  logic    push;
  logic    pop;
  logic    q_full;
  logic    q_valid;

  abtd_derive u_derive (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .drv       (drv)
  );

  abtd_front u_front (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tlast   (s_tlast),
    .n_len     (drv.n_len),
    .q_full    (q_full),
    .push      (push),
    .push_data (push_data),
    .wr        (wr)
  );

  abtd_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .full      (q_full),
    .valid     (q_valid),
    .rd_data   (q_data)
  );

  abtd_back u_back (
    .clk      (clk),
    .rst      (rst),
    .drv      (drv),
    .q_valid  (q_valid),
    .q_data   (q_data),
    .pop      (pop),
    .wr       (wr),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
  );

endmodule

// File: tb/sv/plaintext_checker.sv
module plaintext_checker import abtd_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  input  logic                 s_tready,
  input  logic [7:0]           s_tdata,   // cipher_byte
  input  logic                 s_tlast,
  input  logic                 m_tvalid,
  input  logic                 m_tready,
  input  logic [7:0]           m_tdata,   // plain_byte
  input  logic                 m_tlast,
  input  logic                 m_tuser,   // message_done
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [LEN_W-1:0]     cfg_data,
  output int                   failures,
  output int                   pending
);

  typedef struct packed {
    logic [7:0] plain;
    logic       run_last;
    logic       done;
  } plain_beat_t;

  plain_beat_t decoded_q[$];

  logic [LEN_W-1:0]  blk_len;
  logic [ADDR_W-1:0] mult;
  logic [ADDR_W-1:0] offs;
  logic [7:0]        cipher_store [MAX_BLOCK];
  int unsigned       fill;
  int unsigned       inv_mult;
  int unsigned       inv_off;

  function automatic int unsigned block_size();
    int unsigned len;
    len = 32'(blk_len);
    if (len == 0) return 1;
    if (len > MAX_BLOCK) return MAX_BLOCK;
    return len;
  endfunction

  function void find_inverse();
    int unsigned n;
    int unsigned m;
    n = block_size();
    m = 32'(mult) % n;
    inv_mult = 0;
    for (int unsigned i = 1; i < n; i++) begin
      if ((m * i) % n == 1) begin
        inv_mult = i;
        break;
      end
    end
    inv_off = n - ((inv_mult * 32'(offs)) % n);
  endfunction

  // store one cipher byte; on a flush queue the decoded run
  function void decode_byte(input logic [7:0] cb, input logic msg_end);
    int unsigned n;
    int unsigned p;
    int unsigned cnt;
    logic [7:0]  blk [MAX_BLOCK];
    logic [7:0]  run [MAX_BLOCK];
    plain_beat_t beat;
    n = block_size();
    cnt = 0;
    if (fill < MAX_BLOCK) begin
      cipher_store[fill] = cb;
      fill++;
    end
    if (!(msg_end || fill >= n)) return;
    for (int unsigned j = 0; j < n; j++) blk[j] = (j < fill) ? cipher_store[j] : PAD_CHAR;
    fill = 0;
    for (int unsigned j = 0; j < n; j++) begin
      p = (inv_mult * j + inv_off) % n;
      if (blk[p] != PAD_CHAR) begin
        run[cnt] = blk[p];
        cnt++;
      end
    end
    for (int unsigned k = 0; k < cnt; k++) begin
      beat.plain    = run[k];
      beat.run_last = (k == cnt - 1);
      beat.done     = msg_end;
      decoded_q.push_back(beat);
    end
  endfunction

  initial begin
    failures = 0;
    pending  = 0;
  end

  always @(posedge clk) begin
    plain_beat_t want;
    if (rst) begin
      decoded_q.delete();
      blk_len = RST_BLOCK_LEN;
      mult    = RST_MULTIPLIER;
      offs    = RST_OFFSET;
      fill    = 0;
      for (int i = 0; i < MAX_BLOCK; i++) cipher_store[i] = '0;
      find_inverse();
    end else begin
      // output beat first: a byte accepted on this edge cannot have caused it
      if (m_tvalid && m_tready) begin
        if (decoded_q.size() == 0) begin
          $error("unexpected output beat: plain_byte %h", m_tdata);
          failures++;
        end else begin
          want = decoded_q.pop_front();
          if (m_tdata !== want.plain) begin
            $error("plain_byte: expected %h, got %h", want.plain, m_tdata);
            failures++;
          end
          if (m_tlast !== want.run_last) begin
            $error("run_last: expected %b, got %b", want.run_last, m_tlast);
            failures++;
          end
          if (m_tuser !== want.done) begin
            $error("message_done: expected %b, got %b", want.done, m_tuser);
            failures++;
          end
        end
      end
      if (cfg_we) begin
        case (cfg_index)
          CFG_BLOCK_LEN: begin
            blk_len = cfg_data;
            find_inverse();
          end
          CFG_MULTIPLIER: begin
            mult = cfg_data[ADDR_W-1:0];
            find_inverse();
          end
          CFG_OFFSET: begin
            offs = cfg_data[ADDR_W-1:0];
            find_inverse();
          end
          default: ;
        endcase
      end
      if (s_tvalid && s_tready) decode_byte(s_tdata, s_tlast);
    end
    pending = decoded_q.size();
  end

endmodule

// File: tb/sv/testbench.sv
module testbench;
  import abtd_pkg::*;

  localparam int CLK_PERIOD     = 12;
  localparam int SETTLE_CYCLES  = 300;
  localparam int RX_HOLD_CYCLES = 400;
  localparam int TIMEOUT        = 400000 * CLK_PERIOD;
  localparam int NUM_PHASES     = 12;
  localparam int PRESSURE_PHASE = 6;
  localparam int PAUSE_PHASE    = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
  localparam int PHASE_LEN [NUM_PHASES] = '{1, 127, 2, 3, 8, 5, 8, 64, 7, 65, 13, 4};

  logic                 clk;
  logic                 rst;
  logic                 s_tvalid;
  logic                 s_tready;
  logic [7:0]           s_tdata;   // cipher_byte
  logic                 s_tlast;
  logic                 m_tvalid;
  logic                 m_tready;
  logic [7:0]           m_tdata;   // plain_byte
  logic                 m_tlast;
  logic                 m_tuser;   // message_done
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [LEN_W-1:0]     cfg_data;
  int                   failures;
  int                   pending;

  logic tx_burst;
  logic tx_fast;
  logic rx_hold_req;

  affine_block_transposition_decoder_top dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tlast   (s_tlast),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast),
    .m_tuser   (m_tuser),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  plaintext_checker u_checker (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tlast   (s_tlast),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast),
    .m_tuser   (m_tuser),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .failures  (failures),
    .pending   (pending)
  );

  initial begin
    clk = 1'b0;
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  initial begin
    #(TIMEOUT);
    $display("Mismatches found");
    $finish;
  end

  task automatic send_byte(input logic [7:0] b, input logic msg_end);
    int gap;
    gap = tx_burst ? 0 : (tx_fast ? $urandom_range(0, 1) : $urandom_range(0, 16));
    repeat (gap) @(negedge clk) s_tvalid <= 1'b0;
    @(negedge clk);
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    s_tlast  <= msg_end;
    do @(posedge clk); while (!(s_tvalid && s_tready));
  endtask

  // stop offering, let every expected beat arrive, then cover a read-out
  // of pads only and the inverse search
  task automatic wait_idle();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [LEN_W-1:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  // output side: per-beat stall, occasional stall-free stretches, one long hold-off
  initial begin : sink
    int gap;
    int beats;
    logic rx_burst;
    m_tready = 1'b0;
    beats    = 0;
    rx_burst = 1'b0;
    while (rst !== 1'b0) @(negedge clk);
    forever begin
      if (rx_hold_req) begin
        rx_hold_req = 1'b0;
        repeat (RX_HOLD_CYCLES) @(negedge clk) m_tready <= 1'b0;
      end
      if (beats % 48 == 0) rx_burst = ($urandom_range(0, 3) == 0);
      gap = rx_burst ? 0 : $urandom_range(0, 16);
      repeat (gap) @(negedge clk) m_tready <= 1'b0;
      @(negedge clk) m_tready <= 1'b1;
      do @(posedge clk); while (!(m_tvalid && m_tready));
      beats++;
    end
  end

  initial begin : stimulus
    int n;
    int items;
    int msg_left;
    logic [LEN_W-1:0] len_val;
    logic [LEN_W-1:0] mult_val;
    logic [LEN_W-1:0] off_val;
    logic [7:0] b;
    logic msg_end;

    rst         = 1'b1;
    s_tvalid    = 1'b0;
    s_tdata     = '0;
    s_tlast     = 1'b0;
    cfg_we      = 1'b0;
    cfg_index   = CFG_BLOCK_LEN;
    cfg_data    = '0;
    tx_burst    = 1'b0;
    tx_fast     = 1'b0;
    rx_hold_req = 1'b0;
    repeat (6) @(negedge clk);
    rst <= 1'b0;
    wait_idle();

    // default settings decode in order; a real '*' byte is dropped
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(PAD_CHAR, 1'b0);
    send_byte(8'h01, 1'b0);
    send_byte(8'h80, 1'b0);
    send_byte(8'h7F, 1'b0);
    send_byte(8'h55, 1'b0);
    send_byte(8'hAA, 1'b0);
    // short message padded at its end
    send_byte(8'h11, 1'b0);
    send_byte(8'h22, 1'b0);
    send_byte(8'h33, 1'b1);
    // a flush of nothing but pads gives no beat
    send_byte(PAD_CHAR, 1'b1);
    // block shortened with bytes already held beyond the new length
    send_byte(8'h41, 1'b0);
    send_byte(8'h42, 1'b0);
    send_byte(8'h43, 1'b0);
    send_byte(8'h44, 1'b0);
    send_byte(8'h45, 1'b0);
    wait_idle();
    write_reg(CFG_BLOCK_LEN, 7'd3);
    send_byte(8'h46, 1'b0);
    wait_idle();
    // multiplier with no inverse modulo the length
    write_reg(CFG_MULTIPLIER, 7'd3);
    send_byte(8'h61, 1'b0);
    send_byte(8'h62, 1'b0);
    send_byte(8'h63, 1'b0);
    wait_idle();
    // unused index is ignored; high data bit of the multiplier is dropped
    write_reg(CFG_UNUSED, 7'h55);
    write_reg(CFG_OFFSET, 7'd63);
    write_reg(CFG_MULTIPLIER, 7'h41);
    send_byte(8'hC1, 1'b0);
    send_byte(8'hC2, 1'b1);
    wait_idle();
    // zero length acts as one
    write_reg(CFG_BLOCK_LEN, 7'd0);
    send_byte(PAD_CHAR, 1'b0);
    send_byte(8'h99, 1'b1);

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      wait_idle();
      len_val  = LEN_W'(PHASE_LEN[ph]);
      mult_val = (ph == 0) ? 7'd63 : (ph == 1) ? 7'd0 : 7'($urandom_range(0, 127));
      off_val  = (ph == 0) ? 7'd63 : (ph == 1) ? 7'd0 : 7'($urandom_range(0, 127));
      if ($urandom_range(0, 1) == 1) begin
        write_reg(CFG_BLOCK_LEN, len_val);
        write_reg(CFG_MULTIPLIER, mult_val);
        write_reg(CFG_OFFSET, off_val);
      end else begin
        write_reg(CFG_OFFSET, off_val);
        write_reg(CFG_MULTIPLIER, mult_val);
        write_reg(CFG_BLOCK_LEN, len_val);
      end
      if ($urandom_range(0, 3) == 0) write_reg(CFG_UNUSED, 7'($urandom_range(0, 127)));

      n        = (int'(len_val) == 0) ? 1 :
                 (int'(len_val) > MAX_BLOCK) ? MAX_BLOCK : int'(len_val);
      items    = (n == MAX_BLOCK) ? 70 : 20;
      tx_burst = (ph % 4 == 1);
      tx_fast  = (ph == PRESSURE_PHASE);
      if (ph == PRESSURE_PHASE) rx_hold_req = 1'b1;
      msg_left = 0;

      for (int k = 0; k < items; k++) begin
        if (ph == PAUSE_PHASE && k == items / 2) wait_idle();
        if (msg_left == 0) begin
          msg_left = ($urandom_range(0, 5) == 0) ? $urandom_range(1, 2)
                                                 : $urandom_range(1, 3 * n);
        end
        b       = ($urandom_range(0, 7) == 0) ? PAD_CHAR : 8'($urandom_range(0, 255));
        // occasional early end breaks a message off
        msg_end = (msg_left == 1) || ($urandom_range(0, 31) == 0);
        msg_left = msg_end ? 0 : msg_left - 1;
        send_byte(b, msg_end);
      end
    end

    wait_idle();
    if (failures == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
